[rtl/hmq_pkg.sv]
// Shared types and codes for the binary min-heap priority queue.
package hmq_pkg;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [15:0] priority_key;
    logic [15:0] entry_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [15:0] out_tag;
    logic [7:0]  occupancy;
  } out_word_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

[rtl/binary_min_heap_queue.sv]
// Binary min-heap priority queue top level: handshakes and output register.
//
//  channel | direction | valid       | stall       | word
//  --------+-----------+-------------+-------------+--------------------------
//  input   | in        | in_valid_i  | in_stall_o  | in_word_i  (op, key, tag)
//  result  | out       | out_valid_o | out_stall_i | out_word_o (status, key,
//          |           |             |             |   tag, occupancy)
//
// An empty remove or a full insert needs no memory access; an insert climbs
// one parent per level, and a remove reads the root and the last entry, then
// sinks one level at a time. The one registered memory read port and the
// shared key comparator set the pace. The input stalls until the sequencer
// is idle again. Reset clears the entry count, sequencer state and
// out_valid_o. A finished word waits under out_stall_i.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hmq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hmq_pkg::out_word_t out_word_o
);

  hmq_pkg::eng_stat_t stat;
  hmq_pkg::out_word_t res;
  logic               out_free;
  logic               start;
  logic               out_valid_q;
  hmq_pkg::out_word_t out_word_q;

  // output register can take a word when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // take a new word whenever the sequencer is idle
  assign in_stall_o = !stat.idle;
  assign start      = in_valid_i && stat.idle;

  hmq_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .in_word_i (in_word_i),
    .out_free_i(out_free),
    .stat_o    (stat),
    .res_o     (res)
  );

  // load the result when done, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the word while stalled
  always_ff @(posedge clk_i) begin
    if (stat.done && out_free) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/hmq_sift_unit.sv]
// Shared key comparator and heap index arithmetic used by every sift step.
module hmq_sift_unit #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic [15:0]                          a_key_i,
  input  logic [15:0]                          b_key_i,
  input  logic [$clog2(CAPACITY)-1:0]          pos_i,
  input  logic [$clog2(CAPACITY+1)-1:0]        count_i,
  output logic                                 lt_o,
  output logic [$clog2(CAPACITY)-1:0]          parent_o,
  output logic [$clog2(CAPACITY)+1:0]          lc_o,
  output logic [$clog2(CAPACITY)+1:0]          rc_o,
  output logic                                 lc_ok_o,
  output logic                                 rc_ok_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = AW + 2;

  logic [LW-1:0] count_ext;

  assign lt_o      = a_key_i < b_key_i;
  assign parent_o  = AW'((pos_i - 1'b1) >> 1);
  assign lc_o      = {1'b0, pos_i, 1'b1};
  assign rc_o      = {1'b0, pos_i, 1'b0} + LW'(2);
  assign count_ext = LW'(count_i);
  assign lc_ok_o   = lc_o < count_ext;
  assign rc_ok_o   = rc_o < count_ext;

endmodule

[rtl/hmq_engine.sv]
// Heap memory and sift sequencer: one item at a time, at most one memory access per cycle.
module hmq_engine #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hmq_pkg::in_word_t   in_word_i,
  input  logic                out_free_i,
  output hmq_pkg::eng_stat_t  stat_o,
  output hmq_pkg::out_word_t  res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = AW + 2;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_CHK  = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_RM_TOP  = 9'b000001000,
    S_RM_LAST = 9'b000010000,
    S_DN_LC   = 9'b000100000,
    S_DN_L    = 9'b001000000,
    S_DN_R    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic          moved_q, moved_d;
  hmq_pkg::entry_t item_q, item_d;
  hmq_pkg::entry_t best_word_q, best_word_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [15:0]   res_key_q, res_key_d;
  logic [15:0]   res_tag_q, res_tag_d;

  hmq_pkg::entry_t mem_q [CAPACITY];
  hmq_pkg::entry_t rd_q;
  logic            we, re;
  logic [AW-1:0]   wa, ra;
  hmq_pkg::entry_t wd;

  logic [15:0]   a_key, b_key;
  logic          lt;
  logic [AW-1:0] parent;
  logic [LW-1:0] lc, rc;
  logic          lc_ok, rc_ok;

  hmq_sift_unit #(
    .CAPACITY(CAPACITY)
  ) u_unit (
    .a_key_i (a_key),
    .b_key_i (b_key),
    .pos_i   (pos_q),
    .count_i (count_q),
    .lt_o    (lt),
    .parent_o(parent),
    .lc_o    (lc),
    .rc_o    (rc),
    .lc_ok_o (lc_ok),
    .rc_ok_o (rc_ok)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    best_idx_d   = best_idx_q;
    moved_d      = moved_q;
    item_d       = item_q;
    best_word_d  = best_word_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_tag_d    = res_tag_q;
    we           = 1'b0;
    wa           = pos_q;
    wd           = item_q;
    re           = 1'b0;
    ra           = '0;
    a_key        = rd_q.key;
    b_key        = item_q.key;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d    = '{key: in_word_i.priority_key, tag: in_word_i.entry_tag};
          res_key_d = '0;
          res_tag_d = '0;
          if (in_word_i.operation == hmq_pkg::OP_INSERT) begin
            if (count_q >= CW'(CAPACITY)) begin
              res_status_d = hmq_pkg::ST_FULL;
              state_d      = S_DONE;
            end else begin
              pos_d        = AW'(count_q);
              res_status_d = hmq_pkg::ST_INSERTED;
              state_d      = S_UP_CHK;
            end
          end else if (count_q == '0) begin
            res_status_d = hmq_pkg::ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            re           = 1'b1;
            res_status_d = hmq_pkg::ST_REMOVED;
            state_d      = S_RM_TOP;
          end
        end
      end
      S_UP_CHK: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          count_d = CW'(count_q + 1'b1);
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          ra      = parent;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // new entry against its parent: move the parent down into the hole, else write the entry there
        a_key = item_q.key;
        b_key = rd_q.key;
        we    = 1'b1;
        if (lt) begin
          wd      = rd_q;
          pos_d   = parent;
          state_d = S_UP_CHK;
        end else begin
          count_d = CW'(count_q + 1'b1);
          state_d = S_DONE;
        end
      end
      S_RM_TOP: begin
        res_key_d = rd_q.key;
        res_tag_d = rd_q.tag;
        re        = 1'b1;
        ra        = AW'(count_q - 1'b1);
        count_d   = CW'(count_q - 1'b1);
        state_d   = S_RM_LAST;
      end
      S_RM_LAST: begin
        item_d  = rd_q;
        pos_d   = '0;
        state_d = S_DN_LC;
      end
      S_DN_LC: begin
        if (!lc_ok) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          ra      = lc[AW-1:0];
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        // left child against the moving entry
        if (lt) begin
          best_word_d = rd_q;
          best_idx_d  = lc[AW-1:0];
          moved_d     = 1'b1;
        end else begin
          best_word_d = item_q;
          moved_d     = 1'b0;
        end
        if (rc_ok) begin
          re = 1'b1;
          ra = rc[AW-1:0];
        end
        state_d = S_DN_R;
      end
      S_DN_R: begin
        // right child against the best so far; a tie keeps the earlier pick
        b_key = best_word_q.key;
        we    = 1'b1;
        if (rc_ok && lt) begin
          wd      = rd_q;
          pos_d   = rc[AW-1:0];
          state_d = S_DN_LC;
        end else if (moved_q) begin
          wd      = best_word_q;
          pos_d   = best_idx_q;
          state_d = S_DN_LC;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    best_idx_q   <= best_idx_d;
    moved_q      <= moved_d;
    item_q       <= item_d;
    best_word_q  <= best_word_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_tag_q    <= res_tag_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  assign stat_o.idle = state_q == S_IDLE;
  assign stat_o.done = state_q == S_DONE;

  assign res_o.status    = res_status_q;
  assign res_o.out_key   = res_key_q;
  assign res_o.out_tag   = res_tag_q;
  assign res_o.occupancy = 8'(count_q);

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == CW'($past(count_q) + 1'b1) || count_q == CW'($past(count_q) - 1'b1)))
    else $error("entry count moved by more than one");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_dn_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DN_L) |-> (lc_ok && (LW'(pos_q) < LW'(count_q))))
    else $error("sift-down read outside the held entries");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free_i) |=> (state_q == S_DONE && $stable(count_q)))
    else $error("result dropped while output register busy");

endmodule
